@@ design/bfaa_pkg.sv @@
// Package for the best-fit arena allocator: sizes, register address, status codes, request kinds, FSM states.
// No dependencies.
package bfaa_pkg;

    localparam int MAX_NODES  = 64;
    localparam int ARENA_BITS = 20;
    localparam logic [19:0] ARENA_RESET = 20'd65536;

    localparam logic [1:0] REG_ARENA_SIZE = 2'd0;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_EV,
        S_BEST_RD,
        S_BEST_EV,
        S_SPLIT_P,
        S_SPLIT_W,
        S_FREE_N_RD,
        S_FREE_N_EV,
        S_FREE_N_NN,
        S_FREE_P_RD,
        S_FREE_P_EV,
        S_FREE_P_NN,
        S_DONE
    } t_state;

endpackage

@@ design/best_fit_arena_allocator_unit.sv @@
// Best-fit arena allocator: top level with node memory and control sequencer.
// Depends on bfaa_pkg.
//
// Node records (prev, next, start, length, hole flag) live in one synchronous memory of
// MAX_NODES entries with one registered read port and one write port; used
// flags are flip-flops, with a count of nodes in use beside them. One transfer on the
// slave stream gives one result on the master stream. An allocate walks the list node
// by node (read, evaluate) and a free walks to its block in the same way, then merges
// it with hole neighbours before the result; no new transfer is accepted until the
// current one has its result in the master output register. A zero or oversized
// allocate answers without a walk. After reset or a write of arena_size, a clearing
// pass over all MAX_NODES entries rewrites the node memory; no input transfer is
// accepted during it. The master output register lets a result wait.
module best_fit_arena_allocator_unit #(
    parameter int MAX_NODES  = bfaa_pkg::MAX_NODES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_size[19:0], block_offset[39:20]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[1:0], offset[21:2], nodes_used[28:22], pad
);
    localparam int ARENA_BITS = bfaa_pkg::ARENA_BITS;
    localparam int IW = $clog2(MAX_NODES);
    localparam int LW = $clog2(MAX_NODES + 1);
    localparam logic [LW-1:0] NUL = LW'(MAX_NODES);

    typedef struct packed {
        logic                  hole;
        logic [LW-1:0]         prev;
        logic [LW-1:0]         next;
        logic [ARENA_BITS-1:0] start;
        logic [ARENA_BITS-1:0] len;
    } t_node;

    t_node mem [MAX_NODES];
    t_node rd_q;
    logic [IW-1:0] rd_a;
    logic          wr_en;
    logic [IW-1:0] wr_a;
    t_node         wr_d;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_a] <= wr_d;
        rd_q <= mem[rd_a];
    end

    bfaa_pkg::t_state r_state, n_state;
    logic [MAX_NODES-1:0] r_used, n_used;
    logic [19:0] r_size, n_size;
    logic [LW-1:0] r_head, n_head, r_cur, n_cur, r_best, n_best, r_b, n_b, r_f, n_f;
    logic [LW-1:0] r_cnt, n_cnt, r_steps, n_steps;
    logic [ARENA_BITS-1:0] r_blen, n_blen, r_need, n_need, r_off, n_off;
    t_node r_nb, n_nb, r_nn, n_nn;
    logic r_kind, n_kind;
    logic [1:0] r_st, n_st;
    logic r_ov, n_ov;
    logic [31:0] r_od, n_od;
    logic [IW-1:0] r_clr, n_clr;

    wire cfg_wr = psel & penable & pwrite & (paddr == bfaa_pkg::REG_ARENA_SIZE);
    assign pready = 1'b1;
    assign prdata = (paddr == bfaa_pkg::REG_ARENA_SIZE) ? {12'd0, r_size} : 32'd0;
    assign s_axis_tready = (r_state == bfaa_pkg::S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    wire [21:0] need_w = {2'b0, s_axis_tdata[19:0]} + 22'd3;

    // lowest free node
    logic [LW-1:0] free_idx;
    always_comb begin
        free_idx = NUL;
        for (int k = MAX_NODES - 1; k >= 0; k--)
            if (!r_used[k]) free_idx = LW'(k);
    end

    function automatic logic [IW-1:0] ix(input logic [LW-1:0] v);
        return v[IW-1:0];
    endfunction

    always_comb begin
        n_state = r_state; n_used = r_used; n_size = r_size; n_head = r_head;
        n_cur = r_cur; n_best = r_best; n_b = r_b; n_f = r_f; n_cnt = r_cnt;
        n_steps = r_steps; n_blen = r_blen; n_need = r_need; n_off = r_off;
        n_nb = r_nb; n_nn = r_nn; n_kind = r_kind; n_st = r_st; n_ov = r_ov;
        n_od = r_od; n_clr = r_clr;
        rd_a = ix(r_cur); wr_en = 1'b0; wr_a = '0;
        wr_d = '{hole: 1'b1, prev: NUL, next: NUL, start: '0, len: '0};
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        case (r_state)
            bfaa_pkg::S_CLEAR: begin
                wr_en = 1'b1; wr_a = r_clr;
                if (r_clr == '0) wr_d.len = ARENA_BITS'(r_size);
                n_clr = r_clr + 1'b1;
                if (r_clr == IW'(MAX_NODES - 1)) n_state = bfaa_pkg::S_IDLE;
            end
            bfaa_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind = s_axis_tuser;
                    n_need = ARENA_BITS'({need_w[21:2], 2'b00});
                    n_off = ARENA_BITS'(s_axis_tdata[39:20]);
                    n_cur = r_head; n_best = NUL; n_b = NUL; n_steps = '0;
                    n_st = bfaa_pkg::ST_OK;
                    // zero request, or one that rounds up past any arena size
                    if (s_axis_tuser == bfaa_pkg::KIND_ALLOC &&
                        (need_w[21:2] == '0 || need_w[21:20] != 2'b00)) begin
                        n_st = bfaa_pkg::ST_NOFIT; n_off = '0;
                        n_state = bfaa_pkg::S_DONE;
                    end else n_state = bfaa_pkg::S_WALK_RD;
                end
            end
            bfaa_pkg::S_WALK_RD: begin
                rd_a = ix(r_cur);
                if (r_cur >= NUL || r_steps == NUL)
                    n_state = r_kind ? bfaa_pkg::S_DONE : bfaa_pkg::S_BEST_RD;
                else n_state = bfaa_pkg::S_WALK_EV;
                if (r_kind && (r_cur >= NUL || r_steps == NUL)) begin
                    n_st = bfaa_pkg::ST_NOTFOUND; n_off = '0;
                end
            end
            bfaa_pkg::S_WALK_EV: begin
                n_steps = r_steps + 1'b1;
                n_cur = rd_q.next;
                n_state = bfaa_pkg::S_WALK_RD;
                if (!r_kind) begin
                    if (r_used[ix(r_cur)] && rd_q.hole && rd_q.len >= r_need &&
                        (r_best == NUL || rd_q.len < r_blen)) begin
                        n_best = r_cur; n_blen = rd_q.len;
                    end
                end else if (r_used[ix(r_cur)] && !rd_q.hole && rd_q.start == r_off) begin
                    n_b = r_cur; n_nb = rd_q; n_nb.hole = 1'b1;
                    n_state = bfaa_pkg::S_FREE_N_RD;
                end
            end
            bfaa_pkg::S_BEST_RD: begin
                rd_a = ix(r_best);
                if (r_best == NUL) begin
                    n_st = bfaa_pkg::ST_NOFIT; n_off = '0; n_state = bfaa_pkg::S_DONE;
                end else n_state = bfaa_pkg::S_BEST_EV;
            end
            bfaa_pkg::S_BEST_EV: begin
                n_nb = rd_q;
                if (rd_q.len == r_need) begin
                    wr_en = 1'b1; wr_a = ix(r_best); wr_d = rd_q; wr_d.hole = 1'b0;
                    n_off = rd_q.start; n_state = bfaa_pkg::S_DONE;
                end else if (free_idx == NUL) begin
                    n_st = bfaa_pkg::ST_FULL; n_off = '0; n_state = bfaa_pkg::S_DONE;
                end else begin
                    n_f = free_idx;
                    wr_en = 1'b1; wr_a = ix(free_idx);
                    wr_d = '{hole: 1'b0, prev: rd_q.prev, next: r_best,
                             start: rd_q.start, len: r_need};
                    n_used[ix(free_idx)] = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_off = rd_q.start;
                    n_state = bfaa_pkg::S_SPLIT_W;
                end
            end
            bfaa_pkg::S_SPLIT_W: begin
                wr_en = 1'b1; wr_a = ix(r_best); wr_d = r_nb;
                wr_d.prev = r_f; wr_d.start = r_nb.start + r_need;
                wr_d.len = r_nb.len - r_need;
                if (r_nb.prev == NUL) begin
                    n_head = r_f; n_state = bfaa_pkg::S_DONE;
                end else begin
                    rd_a = ix(r_nb.prev); n_state = bfaa_pkg::S_SPLIT_P;
                end
            end
            bfaa_pkg::S_SPLIT_P: begin
                wr_en = 1'b1; wr_a = ix(r_nb.prev); wr_d = rd_q; wr_d.next = r_f;
                n_state = bfaa_pkg::S_DONE;
            end
            bfaa_pkg::S_FREE_N_RD: begin
                rd_a = ix(r_nb.next);
                n_state = (r_nb.next < NUL && r_used[ix(r_nb.next)]) ?
                          bfaa_pkg::S_FREE_N_EV : bfaa_pkg::S_FREE_P_RD;
            end
            bfaa_pkg::S_FREE_N_EV: begin
                n_state = bfaa_pkg::S_FREE_P_RD;
                if (rd_q.hole) begin
                    n_nn = rd_q;
                    wr_en = 1'b1; wr_a = ix(r_nb.next);
                    n_used[ix(r_nb.next)] = 1'b0;
                    n_cnt = r_cnt - 1'b1;
                    n_nb.len = r_nb.len + rd_q.len; n_nb.next = rd_q.next;
                    if (rd_q.next != NUL) begin
                        rd_a = ix(rd_q.next); n_state = bfaa_pkg::S_FREE_N_NN;
                    end
                end
            end
            bfaa_pkg::S_FREE_N_NN: begin
                wr_en = 1'b1; wr_a = ix(r_nn.next); wr_d = rd_q; wr_d.prev = r_b;
                n_state = bfaa_pkg::S_FREE_P_RD;
            end
            bfaa_pkg::S_FREE_P_RD: begin
                wr_en = 1'b1; wr_a = ix(r_b); wr_d = r_nb;
                rd_a = ix(r_nb.prev);
                n_state = (r_nb.prev < NUL && r_used[ix(r_nb.prev)]) ?
                          bfaa_pkg::S_FREE_P_EV : bfaa_pkg::S_DONE;
            end
            bfaa_pkg::S_FREE_P_EV: begin
                n_state = bfaa_pkg::S_DONE;
                if (rd_q.hole) begin
                    wr_en = 1'b1; wr_a = ix(r_nb.prev); wr_d = rd_q;
                    wr_d.len = rd_q.len + r_nb.len; wr_d.next = r_nb.next;
                    n_used[ix(r_b)] = 1'b0;
                    n_cnt = r_cnt - 1'b1;
                    if (r_nb.next != NUL) begin
                        rd_a = ix(r_nb.next); n_state = bfaa_pkg::S_FREE_P_NN;
                    end
                end
            end
            bfaa_pkg::S_FREE_P_NN: begin
                // released node b content is don't-care once unused; fix next's prev
                wr_en = 1'b1; wr_a = ix(r_nb.next); wr_d = rd_q; wr_d.prev = r_nb.prev;
                n_state = bfaa_pkg::S_DONE;
            end
            bfaa_pkg::S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov = 1'b1;
                    n_od = {3'd0, 7'(r_cnt), 20'(r_off), r_st};
                    if (r_kind) n_od[21:2] = '0;
                    n_state = bfaa_pkg::S_IDLE;
                end
            end
            default: n_state = bfaa_pkg::S_IDLE;
        endcase
        if (cfg_wr) begin
            n_size = {pwdata[19:2], 2'b00};
            n_used = '0; n_used[0] = 1'b1; n_head = '0; n_clr = '0;
            n_cnt = LW'(1);
            n_state = bfaa_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfaa_pkg::S_CLEAR;
            r_used <= MAX_NODES'(1);
            r_size <= bfaa_pkg::ARENA_RESET;
            r_head <= '0; r_clr <= '0; r_ov <= 1'b0;
            r_cnt <= LW'(1);
        end else begin
            r_state <= n_state; r_used <= n_used; r_size <= n_size;
            r_head <= n_head; r_clr <= n_clr; r_ov <= n_ov;
            r_cnt <= n_cnt;
        end
        r_cur <= n_cur; r_best <= n_best; r_b <= n_b; r_f <= n_f;
        r_steps <= n_steps; r_blen <= n_blen; r_need <= n_need; r_off <= n_off;
        r_nb <= n_nb; r_nn <= n_nn; r_kind <= n_kind; r_st <= n_st; r_od <= n_od;
    end
endmodule

@@ tb/best_fit_arena_allocator_unit_test.sv @@
// Testbench for best_fit_arena_allocator_unit: drives alloc/free requests over the slave
// stream, configures arena_size over APB, and checks every result against a best-fit model.
// Depends on bfaa_pkg and the RTL of the block.
module best_fit_arena_allocator_unit_test;

    localparam int NN = bfaa_pkg::MAX_NODES;
    localparam logic [6:0] NIL = 7'(NN);

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] offset;
        logic [6:0]  nodes_used;
    } t_result;

    // best-fit arena model and queue of expected results
    class arena_scoreboard;
        bit          used[NN];
        bit          hole[NN];
        logic [6:0]  prv[NN];
        logic [6:0]  nxt[NN];
        logic [19:0] len[NN];
        logic [19:0] start[NN];
        logic [6:0]  head;
        logic [19:0] size;
        t_result     pending[$];
        int          errors;
        logic [19:0] live_offsets[$];

        function void init(logic [19:0] sz);
            size = {sz[19:2], 2'b00};
            for (int i = 0; i < NN; i++) begin
                used[i] = 0; hole[i] = 1; prv[i] = NIL; nxt[i] = NIL;
                len[i] = 0; start[i] = 0;
            end
            used[0] = 1;
            len[0] = size;
            head = 0;
            live_offsets.delete();
        endfunction

        function void drop(int i);
            used[i] = 0; hole[i] = 1; prv[i] = NIL; nxt[i] = NIL;
            len[i] = 0; start[i] = 0;
        endfunction

        function logic [1:0] alloc(logic [19:0] req, output logic [19:0] off);
            logic [20:0] need;
            int cur, best, f, p;
            need = ({1'b0, req} + 21'd3) & ~21'd3;
            off = 0;
            best = NN;
            cur = head;
            if (need == 0) return bfaa_pkg::ST_NOFIT;
            for (int s = 0; s < NN && cur < NN; s++) begin
                if (used[cur] && hole[cur] && {1'b0, len[cur]} >= need &&
                    (best == NN || len[cur] < len[best]))
                    best = cur;
                cur = nxt[cur];
            end
            if (best == NN) return bfaa_pkg::ST_NOFIT;
            if ({1'b0, len[best]} == need) begin
                hole[best] = 0;
                off = start[best];
                live_offsets.push_back(off);
                return bfaa_pkg::ST_OK;
            end
            for (f = 0; f < NN; f++)
                if (!used[f]) break;
            if (f == NN) return bfaa_pkg::ST_FULL;
            p = prv[best];
            prv[f] = 7'(p);
            nxt[f] = 7'(best);
            prv[best] = 7'(f);
            if (p < NN) nxt[p] = 7'(f);
            else head = 7'(f);
            used[f] = 1; hole[f] = 0;
            start[f] = start[best];
            len[f] = need[19:0];
            start[best] = start[best] + need[19:0];
            len[best] = len[best] - need[19:0];
            off = start[f];
            live_offsets.push_back(off);
            return bfaa_pkg::ST_OK;
        endfunction

        function logic [1:0] release_block(logic [19:0] off);
            int cur, b, n, p;
            cur = head;
            b = NN;
            for (int s = 0; s < NN && cur < NN; s++) begin
                if (used[cur] && !hole[cur] && start[cur] == off) begin
                    b = cur;
                    break;
                end
                cur = nxt[cur];
            end
            if (b == NN) return bfaa_pkg::ST_NOTFOUND;
            hole[b] = 1;
            foreach (live_offsets[k])
                if (live_offsets[k] == off) begin
                    live_offsets.delete(k);
                    break;
                end
            n = nxt[b];
            if (n < NN && used[n] && hole[n]) begin
                len[b] += len[n];
                nxt[b] = nxt[n];
                if (nxt[n] < NN) prv[nxt[n]] = 7'(b);
                drop(n);
            end
            p = prv[b];
            if (p < NN && used[p] && hole[p]) begin
                len[p] += len[b];
                nxt[p] = nxt[b];
                if (nxt[b] < NN) prv[nxt[b]] = 7'(p);
                drop(b);
            end
            return bfaa_pkg::ST_OK;
        endfunction

        function void note_request(logic kind, logic [19:0] req, logic [19:0] boff);
            t_result r;
            int c;
            logic [19:0] off;
            off = 0;
            if (kind == bfaa_pkg::KIND_ALLOC) r.status = alloc(req, off);
            else r.status = release_block(boff);
            r.offset = off;
            c = 0;
            for (int i = 0; i < NN; i++) c += used[i];
            r.nodes_used = 7'(c);
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] data);
            t_result e, a;
            a.status = data[1:0];
            a.offset = data[21:2];
            a.nodes_used = data[28:22];
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, a.status);
                errors++;
            end
            if (a.offset !== e.offset) begin
                $error("offset: expected %0d, actual %0d", e.offset, a.offset);
                errors++;
            end
            if (a.nodes_used !== e.nodes_used) begin
                $error("nodes_used: expected %0d, actual %0d", e.nodes_used, a.nodes_used);
                errors++;
            end
            if (data[31:29] !== 3'b0) begin
                $error("pad: expected 0, actual %0h", data[31:29]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;

    arena_scoreboard sb = new();
    bit  quiet_phase = 0;
    int  hold_off_cycles = 0;
    longint cycle_count = 0;

    best_fit_arena_allocator_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: sample at rising edge, change tready at falling edge
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    initial begin : sink
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 0;
                hold_off_cycles--;
            end else if (burst > 0) begin
                m_axis_tready <= 0;
                burst--;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 0;
                burst = $urandom_range(1, 10) - 1;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic write_arena(logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= bfaa_pkg::REG_ARENA_SIZE;
        pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.init(v[19:0]);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // called at a falling edge; tvalid stays up between back-to-back transfers
    task automatic send_request(logic kind, logic [19:0] req, logic [19:0] boff);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {boff, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(kind, req, boff);
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // random mix: mostly allocations up to max_req, some of random size; frees of live blocks and of random offsets
    task automatic random_phase(int count, int max_req);
        logic [19:0] o;
        for (int k = 0; k < count; k++) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_request(bfaa_pkg::KIND_ALLOC, 20'($urandom_range(1, max_req)),
                             20'($urandom));
            else if (pick < 58)
                send_request(bfaa_pkg::KIND_ALLOC, 20'($urandom), 20'($urandom));
            else if (pick < 92 && sb.live_offsets.size() > 0) begin
                o = sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
                send_request(bfaa_pkg::KIND_FREE, 20'($urandom), o);
            end else
                send_request(bfaa_pkg::KIND_FREE, 20'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        sb.init(bfaa_pkg::ARENA_RESET);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: zero request, unknown offsets, oversize, extremes
        send_request(bfaa_pkg::KIND_ALLOC, 20'd0, 20'd0);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd1, 20'hFFFFF);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd6, 20'd0);
        send_request(bfaa_pkg::KIND_ALLOC, 20'hFFFFF, 20'd0);
        send_request(bfaa_pkg::KIND_ALLOC, 20'hFFFFC, 20'd0);
        send_request(bfaa_pkg::KIND_FREE, 20'hFFFFF, 20'hFFFFF);
        send_request(bfaa_pkg::KIND_FREE, 20'd0, 20'd0);
        send_request(bfaa_pkg::KIND_FREE, 20'd0, 20'd0);
        send_request(bfaa_pkg::KIND_FREE, 20'd0, 20'd4);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd65536 - 20'd12, 20'd0);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd4, 20'd0);
        send_request(bfaa_pkg::KIND_FREE, 20'd0, 20'd12);
        drain();

        // tiny arena: zero size then size four, full-table split and exact fit
        write_arena(32'h3);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd1, 20'd0);
        drain();
        write_arena(32'h4);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd4, 20'd0);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd1, 20'd0);
        send_request(bfaa_pkg::KIND_FREE, 20'd0, 20'd0);
        drain();
        write_arena(32'd256);
        for (int k = 0; k < 66; k++) send_request(bfaa_pkg::KIND_ALLOC, 20'd1, 20'd0);
        send_request(bfaa_pkg::KIND_FREE, 20'd0, 20'd8);
        send_request(bfaa_pkg::KIND_ALLOC, 20'd4, 20'd0);
        drain();

        // small arena, table fills often; long receiver hold-off
        write_arena(32'd1024);
        hold_off_cycles = 2000;
        random_phase(400, 40);
        drain();

        write_arena(32'hFFFFC);
        random_phase(350, 60000);
        drain();

        write_arena(32'hFFFFFFFF);
        random_phase(250, 3000);
        drain();

        write_arena(32'd65536);
        quiet_phase = 1;
        random_phase(250, 2000);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
